// ----- hdl/sbl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types, constants and helpers for the stereo biquad lowpass unit.
// ----------------------------------------------------------------------------
package sbl_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int STATE_BITS    = 48;
    localparam int STATE_FRAC    = STATE_BITS - SAMPLE_BITS - 4;
    localparam int COEF_BITS     = 32;
    localparam int COEF_FRAC_DEF = 30;
    localparam int STEP_W        = 4;
    localparam int INDEX_W       = 2;

    // Last sequencer step of one frame
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd11;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_FEEDFORWARD_GAIN = 2'd0;
    localparam logic [INDEX_W-1:0] REG_FEEDBACK_ONE     = 2'd1;
    localparam logic [INDEX_W-1:0] REG_FEEDBACK_TWO     = 2'd2;

    localparam logic signed [COEF_BITS-1:0] RST_FEEDFORWARD_GAIN = 32'sd966040000;
    localparam logic signed [COEF_BITS-1:0] RST_FEEDBACK_ONE     = 32'sd1920900000;
    localparam logic signed [COEF_BITS-1:0] RST_FEEDBACK_TWO     = 32'sd869000000;

    localparam logic signed [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } frame_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } frame_out_t;

    // Sequencer to lane control
    typedef struct packed {
        logic              load;
        logic              run;
        logic [STEP_W-1:0] step;
    } ctrl_t;

    function automatic logic signed [STATE_BITS+1:0] ext_state(
        input logic signed [STATE_BITS-1:0] v
    );
        return {{2{v[STATE_BITS-1]}}, v};
    endfunction

    // Clamp a sum of up to three state words back into the state range
    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [STATE_BITS+1:0] v
    );
        logic [2:0] top;
        top = v[STATE_BITS+1:STATE_BITS-1];
        if (top == 3'b000 || top == 3'b111)
            return v[STATE_BITS-1:0];
        else if (v[STATE_BITS+1])
            return STATE_MIN;
        else
            return STATE_MAX;
    endfunction

endpackage

// ----- hdl/sbl_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_lane
// One channel of the biquad: a 25x32 multiplier, an 80-bit accumulator that
// assembles 48x32 products from two partial products, and the state words.
// ----------------------------------------------------------------------------
module sbl_lane
    import sbl_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctrl_t                         ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [COEF_BITS-1:0]   gain,
    input  logic signed [COEF_BITS-1:0]   fb_one,
    input  logic signed [COEF_BITS-1:0]   fb_two,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int PIECE_W = STATE_BITS / 2;
    localparam int PP_W    = PIECE_W + 1 + COEF_BITS;
    localparam int ACC_W   = STATE_BITS + COEF_BITS;
    localparam int RND_W   = STATE_BITS + 1;
    localparam int HEAD_W  = STATE_BITS - SAMPLE_BITS - STATE_FRAC;

    // Multiplier issue steps
    localparam logic [STEP_W-1:0] MUL_P0_LO = 4'd0;
    localparam logic [STEP_W-1:0] MUL_P0_HI = 4'd1;
    localparam logic [STEP_W-1:0] MUL_P1_LO = 4'd2;
    localparam logic [STEP_W-1:0] MUL_P1_HI = 4'd3;
    localparam logic [STEP_W-1:0] MUL_T1_LO = 4'd5;
    localparam logic [STEP_W-1:0] MUL_T1_HI = 4'd6;
    localparam logic [STEP_W-1:0] MUL_T2_LO = 4'd7;
    localparam logic [STEP_W-1:0] MUL_T2_HI = 4'd8;
    // Result capture steps
    localparam logic [STEP_W-1:0] CAP_P0 = 4'd3;
    localparam logic [STEP_W-1:0] CAP_Y  = 4'd4;
    localparam logic [STEP_W-1:0] CAP_P1 = 4'd5;
    localparam logic [STEP_W-1:0] CAP_T1 = 4'd8;
    localparam logic [STEP_W-1:0] CAP_N1 = 4'd9;
    localparam logic [STEP_W-1:0] CAP_T2 = 4'd10;
    localparam logic [STEP_W-1:0] CAP_N2 = 4'd11;

    localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (STATE_FRAC - 1);

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [STATE_BITS-1:0]  s1_reg, s1_next;
    logic signed [STATE_BITS-1:0]  s2_reg, s2_next;
    logic signed [STATE_BITS-1:0]  p0_reg, p1_reg, y_reg, t_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg;
    logic signed [PP_W-1:0]        pp_reg, pp_next;
    logic                          pp_hi_reg, pp_hi_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;

    logic signed [STATE_BITS-1:0]  xs, xs2, op;
    logic signed [COEF_BITS-1:0]   coef;
    logic signed [PIECE_W:0]       piece;
    logic signed [STATE_BITS-1:0]  prod_sat;
    logic                          prod_in_range;
    logic signed [RND_W-1:0]       y_rnd;
    logic                          out_in_range;
    logic signed [SAMPLE_BITS-1:0] out_sat;

    assign xs  = {{HEAD_W{x_reg[SAMPLE_BITS-1]}}, x_reg, {STATE_FRAC{1'b0}}};
    assign xs2 = {xs[STATE_BITS-2:0], 1'b0};

    // Pick operand word, half and coefficient for this step
    always_comb
    begin
        op         = y_reg;
        coef       = fb_two;
        pp_hi_next = 1'b0;
        case (ctrl.step)
            MUL_P0_LO: begin op = xs;    coef = gain;   pp_hi_next = 1'b0; end
            MUL_P0_HI: begin op = xs;    coef = gain;   pp_hi_next = 1'b1; end
            MUL_P1_LO: begin op = xs2;   coef = gain;   pp_hi_next = 1'b0; end
            MUL_P1_HI: begin op = xs2;   coef = gain;   pp_hi_next = 1'b1; end
            MUL_T1_LO: begin op = y_reg; coef = fb_one; pp_hi_next = 1'b0; end
            MUL_T1_HI: begin op = y_reg; coef = fb_one; pp_hi_next = 1'b1; end
            MUL_T2_LO: begin op = y_reg; coef = fb_two; pp_hi_next = 1'b0; end
            MUL_T2_HI: begin op = y_reg; coef = fb_two; pp_hi_next = 1'b1; end
            default:   begin op = y_reg; coef = fb_two; pp_hi_next = 1'b0; end
        endcase
    end

    assign piece   = pp_hi_next ? {op[STATE_BITS-1], op[STATE_BITS-1:PIECE_W]}
                                : {1'b0, op[PIECE_W-1:0]};
    assign pp_next = piece * coef;

    // Low half loads the accumulator, high half adds in shifted
    assign acc_next = pp_hi_reg
                    ? acc_reg + {pp_reg[PP_W-2:0], {PIECE_W{1'b0}}}
                    : {{(ACC_W-PP_W){pp_reg[PP_W-1]}}, pp_reg};

    // Floor shift by the coefficient fraction, clamp to the state range
    assign prod_in_range =
        (&acc_reg[ACC_W-1:COEF_FRAC_BITS+STATE_BITS-1]) |
        (~|acc_reg[ACC_W-1:COEF_FRAC_BITS+STATE_BITS-1]);
    assign prod_sat = prod_in_range
                    ? acc_reg[COEF_FRAC_BITS+STATE_BITS-1:COEF_FRAC_BITS]
                    : (acc_reg[ACC_W-1] ? STATE_MIN : STATE_MAX);

    // Round half up to a sample and clamp
    assign y_rnd        = {y_reg[STATE_BITS-1], y_reg} + RND_HALF;
    assign out_in_range = (&y_rnd[RND_W-1:STATE_FRAC+SAMPLE_BITS-1]) |
                          (~|y_rnd[RND_W-1:STATE_FRAC+SAMPLE_BITS-1]);
    assign out_sat = out_in_range
                   ? y_rnd[STATE_FRAC+SAMPLE_BITS-1:STATE_FRAC]
                   : (y_rnd[RND_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

    assign s1_next = sat_state(ext_state(p1_reg) - ext_state(t_reg) + ext_state(s2_reg));
    assign s2_next = sat_state(ext_state(p0_reg) - ext_state(t_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (ctrl.run)
        begin
            if (ctrl.step == CAP_N1)
                s1_reg <= s1_next;
            if (ctrl.step == CAP_N2)
                s2_reg <= s2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg    <= pp_next;
        pp_hi_reg <= pp_hi_next;
        acc_reg   <= acc_next;
        if (ctrl.load)
            x_reg <= sample;
        if (ctrl.run)
        begin
            if (ctrl.step == CAP_P0)
                p0_reg <= prod_sat;
            if (ctrl.step == CAP_Y)
                y_reg <= sat_state(ext_state(p0_reg) + ext_state(s1_reg));
            if (ctrl.step == CAP_P1)
                p1_reg <= prod_sat;
            if (ctrl.step == CAP_T1 || ctrl.step == CAP_T2)
                t_reg <= prod_sat;
            if (ctrl.step == CAP_N2)
                res_reg <= out_sat;
        end
    end

    assign result = res_reg;

endmodule

// ----- hdl/sbl_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_seq
// Frame sequencer: takes a request, steps both lanes through one frame and
// hands the finished pair to the output stage.
// ----------------------------------------------------------------------------
module sbl_seq
    import sbl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  free,
    output logic  push,
    output ctrl_t ctrl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        push       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (accept)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = S_DONE;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_DONE:
            begin
                // hold the result until the output stage has room
                push = free;
                if (free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign ctrl.load = accept;
    assign ctrl.run  = (state_reg == S_RUN);
    assign ctrl.step = step_reg;

endmodule

// ----- hdl/sbl_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_merge
// Output stage: joins the two lane results into one frame and holds it
// until the receiver takes it.
// ----------------------------------------------------------------------------
module sbl_merge
    import sbl_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic signed [SAMPLE_BITS-1:0] left,
    input  logic signed [SAMPLE_BITS-1:0] right,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_stall,
    output frame_out_t                    out_data
);

    logic       valid_reg;
    frame_out_t data_reg;

    assign free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (push && free)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push && free)
        begin
            data_reg.left_out  <= left;
            data_reg.right_out <= right;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hdl/stereo_biquad_lowpass_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_biquad_lowpass_unit
// Second-order lowpass, transposed direct form II, on stereo frames.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one stereo frame per request; the frame
//   is taken at a clock edge with in_valid high and in_stall low.
//   out_valid/out_stall/out_data return one filtered frame per request.
//   wr_en/wr_index/wr_data load a0 (index 0), b1 (index 1) and b2 (index 2)
//   in signed Q2.COEF_FRAC_BITS; other indexes are ignored. Write them only
//   while no frame is in flight.
//   Both channels run in lockstep on their own lane, each with one 25x32
//   multiplier that builds every 48x32 product from two halves; the lane
//   schedule is 12 steps. After the last step the frame's result is handed to
//   the output register, and no new request is taken before that hand-off.
//   The output register lets the next frame be taken and computed while a
//   result waits; if the receiver still stalls when that frame is done, the
//   unit holds it and keeps in_stall high until the output register frees.
//   Reset clears the filter states to zero, loads the default coefficients
//   and empties the output register.
// ----------------------------------------------------------------------------
module stereo_biquad_lowpass_unit
    import sbl_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  frame_in_t            in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output frame_out_t           out_data,
    input  logic                 wr_en,
    input  logic [INDEX_W-1:0]   wr_index,
    input  logic [COEF_BITS-1:0] wr_data
);

    logic signed [COEF_BITS-1:0]   gain_reg, fb_one_reg, fb_two_reg;
    ctrl_t                         ctrl;
    logic                          push;
    logic                          free;
    logic signed [SAMPLE_BITS-1:0] left_res, right_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= RST_FEEDFORWARD_GAIN;
            fb_one_reg <= RST_FEEDBACK_ONE;
            fb_two_reg <= RST_FEEDBACK_TWO;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FEEDFORWARD_GAIN: gain_reg   <= wr_data;
                REG_FEEDBACK_ONE:     fb_one_reg <= wr_data;
                REG_FEEDBACK_TWO:     fb_two_reg <= wr_data;
                default:              ;
            endcase
        end
    end

    sbl_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .free     (free),
        .push     (push),
        .ctrl     (ctrl)
    );

    sbl_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (in_data.left_sample),
        .gain   (gain_reg),
        .fb_one (fb_one_reg),
        .fb_two (fb_two_reg),
        .result (left_res)
    );

    sbl_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (in_data.right_sample),
        .gain   (gain_reg),
        .fb_one (fb_one_reg),
        .fb_two (fb_two_reg),
        .result (right_res)
    );

    sbl_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .left      (left_res),
        .right     (right_res),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A taken request starts the lanes at their first step
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (ctrl.run && ctrl.step == '0))
        else $error("lanes did not start after a request was taken");

    // No request is taken while the lanes are busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.run |-> (in_stall && !ctrl.load))
        else $error("request taken while lanes are running");

    // A frame is pushed only into a free output register
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> free)
        else $error("push into a full output register");

    // A pushed frame shows up on the output
    a_show: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid)
        else $error("pushed frame not presented");

    // Lanes never run during the hand-off to the output stage
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!ctrl.run && in_stall))
        else $error("hand-off overlaps lane activity");

endmodule

// ----- tb/stereo_biquad_lowpass_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_biquad_lowpass_unit_test
// Self-checking bench for the stereo biquad lowpass unit. A short scripted
// sequence covers the sample extremes, a feedforward-only filter, an ignored
// register index and saturating coefficients. Random frames then run under
// several coefficient sets. Every result is compared with a scripted value or
// with a fixed-point filter model kept in step with the accepted requests.
// ----------------------------------------------------------------------------
module stereo_biquad_lowpass_unit_test;
    import sbl_pkg::*;

    localparam int  SETTLE_CYCLES = 16;
    localparam int  END_CYCLES    = 20;
    localparam int  HOLD_CYCLES   = 120;
    localparam int  PHASE_FRAMES  = 190;
    localparam int  PHASES        = 8;
    localparam int  SCRIPT_ROWS   = 25;
    localparam int  REPORT_LIMIT  = 10;
    localparam real TIMEOUT_NS    = 1000000.0;

    localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] PEAK_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] PEAK_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [COEF_BITS-1:0] COEF_UNITY  = 32'h4000_0000;
    localparam logic [COEF_BITS-1:0] COEF_TOP    = 32'h7FFF_FFFF;
    localparam logic [COEF_BITS-1:0] COEF_BOTTOM = 32'h8000_0000;
    localparam logic [COEF_BITS-1:0] COEF_ZERO   = 32'h0000_0000;

    localparam longint STATE_HI  = STATE_MAX;
    localparam longint STATE_LO  = STATE_MIN;
    localparam longint SAMPLE_HI = PEAK_POS;
    localparam longint SAMPLE_LO = PEAK_NEG;

    typedef enum logic {
        ROW_FRAME,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [INDEX_W-1:0]   index;
        logic [COEF_BITS-1:0] value;
        frame_in_t            frame;
        logic                 typed;
        frame_out_t           want;
    } script_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    frame_in_t            in_data;
    logic                 out_valid;
    logic                 out_stall;
    frame_out_t           out_data;
    logic                 wr_en;
    logic [INDEX_W-1:0]   wr_index;
    logic [COEF_BITS-1:0] wr_data;

    // Filter model: coefficients and per-channel state words
    longint gain_coef;
    longint fb_one_coef;
    longint fb_two_coef;
    longint state_one [2];
    longint state_two [2];

    frame_out_t pending_frames [$];
    int         mismatch_count;
    logic       tx_idling;
    logic       rx_idling;
    logic       long_hold_req;

    stereo_biquad_lowpass_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint clamp_state(input longint v);
        if (v > STATE_HI)
            return STATE_HI;
        if (v < STATE_LO)
            return STATE_LO;
        return v;
    endfunction

    // floor(a * c / 2^frac), clamped to the state range
    function automatic longint coef_product(input longint a, input longint c);
        logic signed [95:0] wide_a;
        logic signed [95:0] wide_c;
        logic signed [95:0] prod;
        longint             res;
        wide_a = a;
        wide_c = c;
        prod = (wide_a * wide_c) >>> COEF_FRAC_DEF;
        if (prod > STATE_HI)
            return STATE_HI;
        if (prod < STATE_LO)
            return STATE_LO;
        res = prod;
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] filter_channel(
        input int                            ch,
        input logic signed [SAMPLE_BITS-1:0] x
    );
        longint scaled;
        longint p0;
        longint p1;
        longint y;
        longint n1;
        longint n2;
        longint r;
        scaled = x;
        scaled = scaled <<< STATE_FRAC;
        p0 = coef_product(scaled, gain_coef);
        p1 = coef_product(scaled * 2, gain_coef);
        y  = clamp_state(p0 + state_one[ch]);
        n1 = clamp_state(p1 - coef_product(y, fb_one_coef) + state_two[ch]);
        n2 = clamp_state(p0 - coef_product(y, fb_two_coef));
        state_one[ch] = n1;
        state_two[ch] = n2;
        // round half up, then clamp to the sample range
        r = (y + (longint'(1) <<< (STATE_FRAC - 1))) >>> STATE_FRAC;
        if (r > SAMPLE_HI)
            r = SAMPLE_HI;
        if (r < SAMPLE_LO)
            r = SAMPLE_LO;
        return r[SAMPLE_BITS-1:0];
    endfunction

    function automatic frame_out_t filter_frame(input frame_in_t f);
        frame_out_t res;
        res.left_out  = filter_channel(0, f.left_sample);
        res.right_out = filter_channel(1, f.right_sample);
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        int v;
        case ($urandom_range(0, 9))
            0: return PEAK_POS;
            1: return PEAK_NEG;
            2:
            begin
                v = $urandom_range(0, 32);
                return v - 16;
            end
            default: return $urandom;
        endcase
    endfunction

    // Coefficients within +/-0.5 keep the feedback stable
    function automatic logic [COEF_BITS-1:0] stable_coef();
        int v;
        v = $urandom_range(0, 32'h4000_0000);
        return v - 32'sh2000_0000;
    endfunction

    task automatic note_mismatch(
        input string                         field,
        input logic signed [SAMPLE_BITS-1:0] want,
        input logic signed [SAMPLE_BITS-1:0] got
    );
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s at %0t: expected %0d, got %0d", field, $realtime,
                     want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        frame_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result at %0t: %0d %0d", $realtime,
                             out_data.left_out, out_data.right_out);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (out_data.left_out !== want.left_out)
                    note_mismatch("left_out", want.left_out, out_data.left_out);
                if (out_data.right_out !== want.right_out)
                    note_mismatch("right_out", want.right_out, out_data.right_out);
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                long_hold_req = 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_frame(
        input frame_in_t  f,
        input logic       typed,
        input frame_out_t want
    );
        frame_out_t predicted;
        if (tx_idling && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        do
            @(posedge clk);
        while (in_stall);
        predicted = filter_frame(f);
        pending_frames.push_back(typed ? want : predicted);
    endtask

    // Drop valid and wait for every pending result, then let the unit go idle
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(
        input logic [INDEX_W-1:0]   index,
        input logic [COEF_BITS-1:0] value
    );
        logic signed [COEF_BITS-1:0] coef;
        coef = value;
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        case (index)
            REG_FEEDFORWARD_GAIN: gain_coef   = coef;
            REG_FEEDBACK_ONE:     fb_one_coef = coef;
            REG_FEEDBACK_TWO:     fb_two_coef = coef;
            default: ;
        endcase
    endtask

    task automatic load_coefs(
        input logic [COEF_BITS-1:0] a0,
        input logic [COEF_BITS-1:0] b1,
        input logic [COEF_BITS-1:0] b2
    );
        write_reg(REG_FEEDFORWARD_GAIN, a0);
        write_reg(REG_FEEDBACK_ONE, b1);
        write_reg(REG_FEEDBACK_TWO, b2);
    endtask

    initial
    begin : stimulus
        script_row_t          script [SCRIPT_ROWS];
        frame_in_t            f;
        logic [COEF_BITS-1:0] a0;
        logic [COEF_BITS-1:0] b1;
        logic [COEF_BITS-1:0] b2;

        in_valid       = 1'b0;
        in_data        = '0;
        wr_en          = 1'b0;
        wr_index       = '0;
        wr_data        = '0;
        tx_idling      = 1'b1;
        rx_idling      = 1'b1;
        long_hold_req  = 1'b0;
        mismatch_count = 0;
        gain_coef      = RST_FEEDFORWARD_GAIN;
        fb_one_coef    = RST_FEEDBACK_ONE;
        fb_two_coef    = RST_FEEDBACK_TWO;
        state_one      = '{0, 0};
        state_two      = '{0, 0};

        // With a0 = 1.0 and no feedback the filter is 1 + 2z^-1 + z^-2
        script = '{
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{24'sd0, 24'sd0}, 1'b1, '{24'sd0, 24'sd0}},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{PEAK_POS, PEAK_NEG}, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{PEAK_NEG, PEAK_POS}, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{24'sd1, -24'sd1}, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{PEAK_POS, PEAK_POS}, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{24'sd0, 24'sd0}, 1'b0, '0},
            '{ROW_WRITE, REG_FEEDFORWARD_GAIN, COEF_UNITY, '0, 1'b0, '0},
            '{ROW_WRITE, REG_FEEDBACK_ONE, COEF_ZERO, '0, 1'b0, '0},
            '{ROW_WRITE, REG_FEEDBACK_TWO, COEF_ZERO, '0, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{24'sd0, 24'sd0}, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{24'sd0, 24'sd0}, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{PEAK_POS, PEAK_NEG}, 1'b1, '{PEAK_POS, PEAK_NEG}},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{24'sd0, 24'sd0}, 1'b1, '{PEAK_POS, PEAK_NEG}},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{24'sd0, 24'sd0}, 1'b1, '{PEAK_POS, PEAK_NEG}},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{24'sd0, 24'sd0}, 1'b1, '{24'sd0, 24'sd0}},
            '{ROW_WRITE, REG_UNUSED, 32'h1234_5678, '0, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{-24'sd5, 24'sd7}, 1'b1, '{-24'sd5, 24'sd7}},
            '{ROW_WRITE, REG_FEEDFORWARD_GAIN, COEF_TOP, '0, 1'b0, '0},
            '{ROW_WRITE, REG_FEEDBACK_ONE, COEF_BOTTOM, '0, 1'b0, '0},
            '{ROW_WRITE, REG_FEEDBACK_TWO, COEF_BOTTOM, '0, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{PEAK_POS, PEAK_NEG}, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{PEAK_POS, PEAK_NEG}, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{PEAK_NEG, PEAK_POS}, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{PEAK_NEG, PEAK_NEG}, 1'b0, '0},
            '{ROW_FRAME, REG_UNUSED, COEF_ZERO, '{24'sd0, 24'sd0}, 1'b0, '0}
        };

        do
            @(posedge clk);
        while (!rst_n);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(script[i].index, script[i].value);
            end
            else
                send_frame(script[i].frame, script[i].typed, script[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                1:
                begin
                    a0 = COEF_ZERO;
                    b1 = COEF_ZERO;
                    b2 = COEF_ZERO;
                end
                2:
                begin
                    a0 = COEF_BOTTOM;
                    b1 = COEF_ZERO;
                    b2 = COEF_ZERO;
                end
                3, 6:
                begin
                    a0 = stable_coef();
                    b1 = stable_coef();
                    b2 = stable_coef();
                end
                4:
                begin
                    a0 = $urandom;
                    b1 = $urandom;
                    b2 = $urandom;
                end
                default:
                begin
                    a0 = RST_FEEDFORWARD_GAIN;
                    b1 = RST_FEEDBACK_ONE;
                    b2 = RST_FEEDBACK_TWO;
                end
            endcase
            load_coefs(a0, b1, b2);
            tx_idling = (phase != PHASES - 1);
            rx_idling = (phase != PHASES - 1);
            // Hold the output side long enough for the unit to back up
            if (phase == 5)
                long_hold_req = 1'b1;
            repeat (PHASE_FRAMES)
            begin
                f.left_sample  = random_sample();
                f.right_sample = random_sample();
                send_frame(f, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
